// ===== rtl/core/riff_webp_frame_prefix_scanner_macros.svh =====
// ----------------------------------------------------------------------------
// RIFF WebP frame prefix scanner: assertion macros
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RIFF_WEBP_FRAME_PREFIX_SCANNER_MACROS_SVH
`define RIFF_WEBP_FRAME_PREFIX_SCANNER_MACROS_SVH

`ifndef SYNTH
// The condition holds at every clock edge outside reset.
`define RWFP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rwfp: invariant violated");
// When the antecedent holds, the consequent holds in the same cycle.
`define RWFP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rwfp: same-cycle implication violated");
// When the antecedent holds, the consequent holds in the next cycle.
`define RWFP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rwfp: next-cycle implication violated");
`else
`define RWFP_ASSERT_ALWAYS(label, cond)
`define RWFP_ASSERT_SAME(label, ante, cons)
`define RWFP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/core/rwfp_pkg.sv =====
// ----------------------------------------------------------------------------
// rwfp_pkg
// Shared types and constants of the RIFF WebP frame prefix scanner.
// ----------------------------------------------------------------------------
package rwfp_pkg;

    // Little-endian four-character codes as they arrive on the byte stream.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
    localparam logic [31:0] TAG_ANMF = 32'h464D_4E41;
    localparam logic [31:0] TAG_VP8  = 32'h2038_5056;
    localparam logic [31:0] TAG_VP8L = 32'h4C38_5056;

    localparam logic [32:0] MIN_TOTAL   = 33'd20;
    localparam logic [32:0] MAX_TOTAL   = 33'h0_4000_0000;
    localparam logic [25:0] LIMIT_RESET = 26'h200_0000;

    localparam int unsigned LIMIT_W   = 26;
    localparam int unsigned BYTES_W   = 26;
    localparam int unsigned PATCHED_W = 25;
    localparam int unsigned OUT_W     = 56;

    localparam logic [2:0] ST_SCANNING  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_BAD_SIG   = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
    localparam logic [2:0] ST_LIMIT     = 3'd4;
    localparam logic [2:0] ST_TRUNCATED = 3'd5;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_ANMF = 2'd1;
    localparam logic [1:0] KIND_VP8  = 2'd2;
    localparam logic [1:0] KIND_VP8L = 2'd3;

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_CHUNK   = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [3:0]  pos;       // byte position within the current header
        logic [25:0] bytes;     // bytes consumed so far
        logic [30:0] total;     // container total, RIFF size plus 8
        logic [31:0] tag;
        logic [31:0] len;
        logic [32:0] left;      // payload bytes still to skip, pad included
        logic [2:0]  status;
        logic [1:0]  kind;
        logic        riff_bad;
    } t_state;

endpackage

// ===== rtl/core/riff_webp_frame_prefix_scanner.sv =====
// ----------------------------------------------------------------------------
// riff_webp_frame_prefix_scanner
// Byte-serial scanner that finds the prefix of a WebP RIFF container up to
// and including its first frame chunk.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bit first)
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tdata: data_byte[7:0]; tuser: input_ends
//  m_axis    out        tdata: scan_status[2:0], prefix_length[28:3],
//                              patched_riff_size[53:29], frame_kind[55:54]
//  cfg       in         i_cfg_wr_data: prefix_limit, written on i_cfg_wr_en
//
// Every input beat produces exactly one result beat. The parser step is
// combinational counters and compares between the state registers and the
// result register, so one byte is taken per clock while the output does not
// stall, and the result appears in the cycle after the beat is accepted. The
// input is ready whenever the result register is empty or is being drained in
// the same cycle, so a stall on the output side holds the input off only while
// a result is waiting. Reset is synchronous and active low; it clears the
// parser state, sets prefix_limit to 32 MiB and empties the result register.
//
// The scanner checks the 12-byte file header, then walks chunk headers and
// skips each payload with its pad byte. Once a final status (frame found or
// an error) is reached it is held, and every later beat returns the same
// result without consuming anything.
// ----------------------------------------------------------------------------
`include "riff_webp_frame_prefix_scanner_macros.svh"

module riff_webp_frame_prefix_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: prefix_limit
    input  logic        i_cfg_wr_en,
    input  logic [25:0] i_cfg_wr_data,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // input_ends
    // Result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // scan_status, prefix_length,
                                        // patched_riff_size, frame_kind
);

    rwfp_pkg::t_state r_state;
    rwfp_pkg::t_state n_state;
    logic [25:0]      r_limit;
    logic             r_out_valid;
    logic [55:0]      r_out_data;
    logic [55:0]      n_out_data;
    logic             in_beat;
    logic [25:0]      patched_full;
    logic [24:0]      patched;
    logic [1:0]       kind;
    logic             report_frame;

    // The result register is free when empty or when its beat leaves now.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    rwfp_next_state u_next (
        .i_state (r_state),
        .i_byte  (s_axis_tdata),
        .i_ends  (s_axis_tuser),
        .i_limit (r_limit),
        .o_state (n_state)
    );

    // The rewritten RIFF size and the kind are shown only with a found frame.
    assign report_frame = (n_state.status == rwfp_pkg::ST_FOUND) &&
                          (n_state.bytes >= 26'd8);
    assign patched_full = n_state.bytes - 26'd8;
    assign patched      = report_frame ? patched_full[24:0] : '0;
    assign kind         = report_frame ? n_state.kind : rwfp_pkg::KIND_NONE;
    assign n_out_data   = {kind, patched, n_state.bytes, n_state.status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= rwfp_pkg::PH_HEADER;
            r_state.pos      <= '0;
            r_state.bytes    <= '0;
            r_state.total    <= '0;
            r_state.tag      <= '0;
            r_state.len      <= '0;
            r_state.left     <= '0;
            r_state.status   <= rwfp_pkg::ST_SCANNING;
            r_state.kind     <= rwfp_pkg::KIND_NONE;
            r_state.riff_bad <= 1'b0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= rwfp_pkg::LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload register: loaded with each accepted beat, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // A final status is never left once reached.
    `RWFP_ASSERT_NEXT(a_done_holds, r_state.phase == rwfp_pkg::PH_DONE, r_state.phase == rwfp_pkg::PH_DONE)
    // A waiting result with a final status matches a finished parser.
    `RWFP_ASSERT_SAME(a_status_done, r_out_valid && (r_out_data[2:0] != rwfp_pkg::ST_SCANNING), r_state.phase == rwfp_pkg::PH_DONE)
    // A frame kind is reported only together with a found frame.
    `RWFP_ASSERT_SAME(a_kind_found, r_out_valid && (r_out_data[55:54] != rwfp_pkg::KIND_NONE), r_out_data[2:0] == rwfp_pkg::ST_FOUND)
    // Each data byte taken while scanning advances the byte count by one.
    `RWFP_ASSERT_NEXT(a_count_step, in_beat && !s_axis_tuser && (r_state.phase != rwfp_pkg::PH_DONE), r_state.bytes == $past(r_state.bytes) + 26'd1)

endmodule

// ===== rtl/core/rwfp_next_state.sv =====
// ----------------------------------------------------------------------------
// rwfp_next_state
// Combinational parser step: next scanner state for one stream beat.
// ----------------------------------------------------------------------------
module rwfp_next_state (
    input  rwfp_pkg::t_state    i_state,
    input  logic [7:0]          i_byte,
    input  logic                i_ends,
    input  logic [25:0]         i_limit,
    output rwfp_pkg::t_state    o_state
);

    // Begin the next chunk header, provided all eight header bytes fit.
    function automatic rwfp_pkg::t_state open_chunk(rwfp_pkg::t_state s,
                                                    logic [25:0] limit);
        logic [26:0]      nxt;
        rwfp_pkg::t_state o;
        o     = s;
        nxt   = {1'b0, s.bytes} + 27'd8;
        o.tag = '0;
        o.len = '0;
        o.pos = '0;
        if ({4'b0, nxt} > s.total) begin
            o.status = rwfp_pkg::ST_BAD_SIZE;
            o.phase  = rwfp_pkg::PH_DONE;
        end else if (nxt > {1'b0, limit}) begin
            o.status = rwfp_pkg::ST_LIMIT;
            o.phase  = rwfp_pkg::PH_DONE;
        end else begin
            o.phase = rwfp_pkg::PH_CHUNK;
        end
        return o;
    endfunction

    // A whole chunk has been consumed: stop on a frame chunk, else go on.
    function automatic rwfp_pkg::t_state finish_chunk(rwfp_pkg::t_state s,
                                                      logic [25:0] limit);
        logic [1:0]       k;
        rwfp_pkg::t_state o;
        o = s;
        priority if (s.tag == rwfp_pkg::TAG_ANMF) k = rwfp_pkg::KIND_ANMF;
        else if (s.tag == rwfp_pkg::TAG_VP8)      k = rwfp_pkg::KIND_VP8;
        else if (s.tag == rwfp_pkg::TAG_VP8L)     k = rwfp_pkg::KIND_VP8L;
        else                                      k = rwfp_pkg::KIND_NONE;
        if (k != rwfp_pkg::KIND_NONE) begin
            o.kind   = k;
            o.status = rwfp_pkg::ST_FOUND;
            o.phase  = rwfp_pkg::PH_DONE;
        end else begin
            o = open_chunk(s, limit);
        end
        return o;
    endfunction

    logic [1:0]  lane;
    logic [32:0] riff_total;
    logic [32:0] pad;
    logic [33:0] chunk_end;
    rwfp_pkg::t_state n;

    assign lane = i_state.pos[1:0];

    always_comb begin
        n          = i_state;
        riff_total = '0;
        pad        = '0;
        chunk_end  = '0;
        if (i_state.phase != rwfp_pkg::PH_DONE) begin
            if (i_ends) begin
                n.status = rwfp_pkg::ST_TRUNCATED;
                n.phase  = rwfp_pkg::PH_DONE;
            end else begin
                n.bytes = i_state.bytes + 26'd1;
                unique case (i_state.phase)
                    rwfp_pkg::PH_HEADER: begin
                        n.pos = i_state.pos + 4'd1;
                        if (i_state.pos < 4'd4) begin
                            n.tag[8*lane +: 8] = i_state.tag[8*lane +: 8] | i_byte;
                            if (i_state.pos == 4'd3) begin
                                n.riff_bad = (n.tag != rwfp_pkg::TAG_RIFF);
                                n.tag      = '0;
                            end
                        end else if (i_state.pos < 4'd8) begin
                            n.len[8*lane +: 8] = i_state.len[8*lane +: 8] | i_byte;
                        end else begin
                            n.tag[8*lane +: 8] = i_state.tag[8*lane +: 8] | i_byte;
                            if (i_state.pos >= 4'd11) begin
                                riff_total = {1'b0, n.len} + 33'd8;
                                if (n.riff_bad || (n.tag != rwfp_pkg::TAG_WEBP)) begin
                                    n.status = rwfp_pkg::ST_BAD_SIG;
                                    n.phase  = rwfp_pkg::PH_DONE;
                                end else if ((riff_total < rwfp_pkg::MIN_TOTAL) ||
                                             (riff_total > rwfp_pkg::MAX_TOTAL)) begin
                                    n.status = rwfp_pkg::ST_BAD_SIZE;
                                    n.phase  = rwfp_pkg::PH_DONE;
                                end else begin
                                    n.total = riff_total[30:0];
                                    n       = open_chunk(n, i_limit);
                                end
                            end
                        end
                    end
                    rwfp_pkg::PH_CHUNK: begin
                        n.pos = i_state.pos + 4'd1;
                        if (i_state.pos < 4'd4) begin
                            n.tag[8*lane +: 8] = i_state.tag[8*lane +: 8] | i_byte;
                        end else begin
                            n.len[8*lane +: 8] = i_state.len[8*lane +: 8] | i_byte;
                            if (i_state.pos >= 4'd7) begin
                                pad       = {1'b0, n.len} + {32'b0, n.len[0]};
                                chunk_end = {1'b0, pad} + {8'b0, n.bytes};
                                if (chunk_end > {3'b0, i_state.total}) begin
                                    n.status = rwfp_pkg::ST_BAD_SIZE;
                                    n.phase  = rwfp_pkg::PH_DONE;
                                end else if (chunk_end > {8'b0, i_limit}) begin
                                    n.status = rwfp_pkg::ST_LIMIT;
                                    n.phase  = rwfp_pkg::PH_DONE;
                                end else begin
                                    n.left = pad;
                                    if (pad == '0) begin
                                        n = finish_chunk(n, i_limit);
                                    end else begin
                                        n.phase = rwfp_pkg::PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                    end
                    rwfp_pkg::PH_PAYLOAD: begin
                        if (i_state.left != '0) begin
                            n.left = i_state.left - 33'd1;
                        end
                        // The count reaches zero on this beat when it was one or less.
                        if (i_state.left <= 33'd1) begin
                            n = finish_chunk(n, i_limit);
                        end
                    end
                    default: begin
                        n = i_state;
                    end
                endcase
            end
        end
        o_state = n;
    end

endmodule

// ===== tb/sv/riff_webp_frame_prefix_scanner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RIFF WebP frame prefix scanner testbench
// Feeds one WebP container byte by byte through the input stream and checks
// every result beat against a typed table row or the cycle-free model below.
// A short table covers the file header, a zero-length chunk and a padded
// chunk that ends exactly on the prefix limit. A long run of random chunks
// follows, then one random ending and a few beats on the held final status.
// ----------------------------------------------------------------------------
module riff_webp_frame_prefix_scanner_tb;

    import rwfp_pkg::*;

    // The limit on the whole run, in clock cycles. The slowest correct run,
    // with the longest gaps on both sides for every beat, stays under a tenth
    // of it.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // The random chunks stop once this many container bytes have been taken.
    localparam int unsigned RANDOM_SPAN = 1050;
    // The table row before which prefix_limit is raised from its low extreme.
    localparam int unsigned RAISE_ROW = 31;
    // The result beat after which the sink holds off, and for how long.
    localparam int unsigned LONG_HOLD_AT     = 200;
    localparam int unsigned LONG_HOLD_CYCLES = 400;

    // One result beat, laid out exactly as m_axis_tdata.
    typedef struct packed {
        logic [1:0]  kind;
        logic [24:0] patched;
        logic [25:0] length;
        logic [2:0]  status;
    } t_scan_result;

    // One row of the directed table. Where typed is set, the expected status
    // and prefix length are given in the row itself.
    typedef struct packed {
        logic [7:0]  data;
        logic        ends;
        logic        typed;
        logic [2:0]  st;
        logic [25:0] length;
    } t_byte_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [25:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;    // data_byte
    logic        s_axis_tuser  = 1'b0;  // input_ends
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;          // scan_status, prefix_length,
                                        // patched_riff_size, frame_kind

    riff_webp_frame_prefix_scanner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Scanner model state, starting from the reset values of the block.
    // ------------------------------------------------------------------------
    t_phase      scan_ph       = PH_HEADER;
    logic [3:0]  scan_pos      = '0;
    logic [25:0] scan_taken    = '0;
    logic [30:0] scan_total    = '0;
    logic [31:0] scan_tag      = '0;
    logic [31:0] scan_len      = '0;
    logic [32:0] scan_left     = '0;
    logic [2:0]  scan_status   = ST_SCANNING;
    logic [1:0]  scan_kind     = KIND_NONE;
    logic        scan_riff_bad = 1'b0;
    logic [25:0] scan_limit    = LIMIT_RESET;

    // Results still owed by the block, oldest first.
    t_scan_result expected_results[$];
    int unsigned  mismatches  = 0;
    int unsigned  feed_calm   = 0;
    int unsigned  cycle_count = 0;

    // Header: "RIFF", a size of 2^30 - 8 (the largest total allowed), "WEBP".
    // Then an ICCP chunk of zero length, which completes on its last header
    // byte, and an EXIF chunk of three bytes whose pad brings its end to 32,
    // exactly the limit in force while it is taken. The limit is raised just
    // before the pad byte, since the pad closes the chunk and the next chunk
    // header would no longer fit under 32.
    t_byte_row directed_rows [32] = '{
        '{8'h52, 1'b0, 1'b1, ST_SCANNING, 26'd1},
        '{8'h49, 1'b0, 1'b1, ST_SCANNING, 26'd2},
        '{8'h46, 1'b0, 1'b1, ST_SCANNING, 26'd3},
        '{8'h46, 1'b0, 1'b1, ST_SCANNING, 26'd4},
        '{8'hF8, 1'b0, 1'b1, ST_SCANNING, 26'd5},
        '{8'hFF, 1'b0, 1'b1, ST_SCANNING, 26'd6},
        '{8'hFF, 1'b0, 1'b1, ST_SCANNING, 26'd7},
        '{8'h3F, 1'b0, 1'b1, ST_SCANNING, 26'd8},
        '{8'h57, 1'b0, 1'b1, ST_SCANNING, 26'd9},
        '{8'h45, 1'b0, 1'b1, ST_SCANNING, 26'd10},
        '{8'h42, 1'b0, 1'b1, ST_SCANNING, 26'd11},
        '{8'h50, 1'b0, 1'b1, ST_SCANNING, 26'd12},
        '{8'h49, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h43, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h43, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h50, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h45, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h58, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h49, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h46, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h03, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'hFF, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h00, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'hA5, 1'b0, 1'b0, ST_SCANNING, 26'd0},
        '{8'h5A, 1'b0, 1'b0, ST_SCANNING, 26'd0}
    };

    // ------------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------------
    function automatic void conclude(input logic [2:0] st);
        scan_status = st;
        scan_ph     = PH_DONE;
    endfunction

    // The next chunk header must fit inside both the container and the limit.
    function automatic void open_next_chunk();
        logic [33:0] header_end;
        header_end = 34'(scan_taken) + 34'd8;
        scan_tag   = '0;
        scan_len   = '0;
        scan_pos   = '0;
        if (header_end > 34'(scan_total)) begin
            conclude(ST_BAD_SIZE);
        end else if (header_end > 34'(scan_limit)) begin
            conclude(ST_LIMIT);
        end else begin
            scan_ph = PH_CHUNK;
        end
    endfunction

    function automatic void close_chunk();
        logic [1:0] kind;
        case (scan_tag)
            TAG_ANMF: kind = KIND_ANMF;
            TAG_VP8:  kind = KIND_VP8;
            TAG_VP8L: kind = KIND_VP8L;
            default:  kind = KIND_NONE;
        endcase
        if (kind != KIND_NONE) begin
            scan_kind = kind;
            conclude(ST_FOUND);
        end else begin
            open_next_chunk();
        end
    endfunction

    // Advances the model by one accepted beat and returns the result it owes.
    function automatic t_scan_result scan_byte(input logic [7:0] b, input logic ends);
        t_scan_result r;
        logic [3:0]   p;
        logic [33:0]  total;
        logic [33:0]  padded;
        logic [33:0]  chunk_end;
        if (scan_ph != PH_DONE) begin
            if (ends) begin
                conclude(ST_TRUNCATED);
            end else begin
                p          = scan_pos;
                scan_taken = scan_taken + 26'd1;
                case (scan_ph)
                    PH_HEADER: begin
                        scan_pos = p + 4'd1;
                        if (p < 4) begin
                            scan_tag[8*p +: 8] = b;
                            // The RIFF tag is judged here but reported only
                            // together with the WEBP tag.
                            if (p == 3) begin
                                scan_riff_bad = (scan_tag != TAG_RIFF);
                                scan_tag      = '0;
                            end
                        end else if (p < 8) begin
                            scan_len[8*(p-4) +: 8] = b;
                        end else begin
                            scan_tag[8*(p-8) +: 8] = b;
                            if (p >= 11) begin
                                total = 34'(scan_len) + 34'd8;
                                if (scan_riff_bad || scan_tag != TAG_WEBP) begin
                                    conclude(ST_BAD_SIG);
                                end else if (total < MIN_TOTAL || total > MAX_TOTAL) begin
                                    conclude(ST_BAD_SIZE);
                                end else begin
                                    scan_total = total[30:0];
                                    open_next_chunk();
                                end
                            end
                        end
                    end
                    PH_CHUNK: begin
                        scan_pos = p + 4'd1;
                        if (p < 4) begin
                            scan_tag[8*p +: 8] = b;
                        end else begin
                            scan_len[8*(p-4) +: 8] = b;
                            if (p >= 7) begin
                                // Odd sizes carry one pad byte after the payload.
                                padded    = 34'(scan_len) + 34'(scan_len[0]);
                                chunk_end = 34'(scan_taken) + padded;
                                if (chunk_end > 34'(scan_total)) begin
                                    conclude(ST_BAD_SIZE);
                                end else if (chunk_end > 34'(scan_limit)) begin
                                    conclude(ST_LIMIT);
                                end else begin
                                    scan_left = padded[32:0];
                                    if (padded == '0) begin
                                        close_chunk();
                                    end else begin
                                        scan_ph = PH_PAYLOAD;
                                    end
                                end
                            end
                        end
                    end
                    default: begin
                        if (scan_left != '0) begin
                            scan_left = scan_left - 33'd1;
                        end
                        if (scan_left == '0) begin
                            close_chunk();
                        end
                    end
                endcase
            end
        end
        r.status = scan_status;
        r.length = scan_taken;
        if (scan_status == ST_FOUND && scan_taken >= 26'd8) begin
            r.patched = 25'(scan_taken - 26'd8);
            r.kind    = scan_kind;
        end else begin
            r.patched = '0;
            r.kind    = KIND_NONE;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then long, and from time to
    // time a calm stretch of back-to-back beats.
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    // Offers one beat and, once it is taken, queues the result it owes. The
    // valid stays high after the beat is taken; the next call either puts a
    // new beat on the bus in that same step or lowers valid for a gap.
    task automatic offer_byte(input logic [7:0] value, input logic ends,
                              input logic use_typed = 1'b0,
                              input t_scan_result typed = '0);
        int unsigned  gap;
        t_scan_result predicted;
        gap = pick_gap(feed_calm);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= ends;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = scan_byte(value, ends);
        expected_results.push_back(use_typed ? typed : predicted);
    endtask

    // prefix_limit is written only with the block idle: no beat offered and
    // every owed result drained.
    task automatic set_limit(input logic [25:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        scan_limit = value;
    endtask

    // A whole chunk: tag, little-endian size, then payload and pad for as long
    // as the scanner is still skipping.
    task automatic emit_chunk(input logic [31:0] tag, input logic [31:0] size);
        for (int k = 0; k < 4; k++) offer_byte(tag[8*k +: 8], 1'b0);
        for (int k = 0; k < 4; k++) offer_byte(size[8*k +: 8], 1'b0);
        while (scan_ph == PH_PAYLOAD) offer_byte(8'($urandom), 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: checks each taken beat against the oldest expectation and
    // stalls at random. Once, after LONG_HOLD_AT beats, it holds off for a
    // long stretch so that the result register fills and the input stalls.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned  stall;
        int unsigned  sink_calm;
        int unsigned  results_seen;
        t_scan_result got;
        t_scan_result want;
        stall        = 0;
        sink_calm    = 0;
        results_seen = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_results.size() == 0) begin
                    $error("result beat %h arrived with nothing expected", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("scan_status", 32'(want.status), 32'(got.status));
                    check_field("prefix_length", 32'(want.length), 32'(got.length));
                    check_field("patched_riff_size", 32'(want.patched), 32'(got.patched));
                    check_field("frame_kind", 32'(want.kind), 32'(got.kind));
                end
                results_seen++;
                stall = (results_seen == LONG_HOLD_AT) ? LONG_HOLD_CYCLES
                                                       : pick_gap(sink_calm);
            end
            if (stall != 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [31:0] tag;
        logic [31:0] size;
        int unsigned r;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting at a limit of 32, on which the padded chunk ends.
        set_limit(26'd32);
        foreach (directed_rows[i]) begin
            if (i == RAISE_ROW) begin
                set_limit(LIMIT_RESET);
            end
            offer_byte(directed_rows[i].data, directed_rows[i].ends,
                       directed_rows[i].typed,
                       {KIND_NONE, 25'd0, directed_rows[i].length, directed_rows[i].st});
        end

        // Random chunks with random content. The limit is moved now and then,
        // always high enough for the whole run, including the all-ones value.
        while (scan_taken < RANDOM_SPAN && scan_ph != PH_DONE) begin
            if ($urandom_range(0, 19) == 0) begin
                case ($urandom_range(0, 2))
                    0:       set_limit(LIMIT_RESET);
                    1:       set_limit('1);
                    default: set_limit(26'($urandom_range(2048, 8191)));
                endcase
            end
            // Known non-frame tags, one of them a near miss of the VP8 tags, else a random one.
            case ($urandom_range(0, 9))
                0:       tag = 32'h5838_5056;    // VP8X
                1:       tag = 32'h4850_4C41;    // ALPH
                2:       tag = 32'h5043_4349;    // ICCP
                3:       tag = 32'h2050_4D58;    // XMP
                default: tag = $urandom;
            endcase
            if (tag == TAG_ANMF || tag == TAG_VP8 || tag == TAG_VP8L) begin
                tag[31] = ~tag[31];
            end
            r = $urandom_range(0, 99);
            if (r < 10)      size = 32'd0;
            else if (r < 80) size = $urandom_range(1, 24);
            else if (r < 95) size = $urandom_range(25, 80);
            else             size = $urandom_range(150, 300);
            emit_chunk(tag, size);
        end

        // One ending per run: a frame chunk most of the time, otherwise a
        // truncated stream, a chunk over the limit or a chunk over the
        // container total.
        case ($urandom_range(0, 9))
            6: begin
                repeat ($urandom_range(0, 5)) offer_byte(8'($urandom), 1'b0);
                offer_byte(8'($urandom), 1'b1);
            end
            7: begin
                case ($urandom_range(0, 2))
                    0:       set_limit('0);
                    1:       set_limit(26'd31);
                    default: set_limit(26'($urandom_range(0, scan_taken + 7)));
                endcase
                emit_chunk($urandom, $urandom_range(0, 40));
            end
            8, 9: begin
                emit_chunk($urandom, $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h4000_0000);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0:       tag = TAG_ANMF;
                    1:       tag = TAG_VP8;
                    default: tag = TAG_VP8L;
                endcase
                emit_chunk(tag, $urandom_range(0, 40));
            end
        endcase

        // The final status must now hold, whatever arrives, the end of the
        // stream included.
        offer_byte(8'($urandom), 1'b1);
        repeat (19) offer_byte(8'($urandom), 1'($urandom_range(0, 1)));

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rwfp_pkg.sv
rtl/core/rwfp_next_state.sv
rtl/core/riff_webp_frame_prefix_scanner.sv
tb/sv/riff_webp_frame_prefix_scanner_tb.sv
